>>> hw/rtl/rrts_pkg.sv
package rrts_pkg;

  // Fixed field widths of the request and result beats
  localparam int unsigned ID_W  = 7;
  localparam int unsigned VAL_W = 32;

  // Per-slot thread state
  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_READY   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_ZOMBIE  = 3'd3,
    ST_CLEAN   = 3'd4
  } slot_state_e;

  // Request kinds
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_EXIT   = 2'd2,
    OP_JOIN   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_NOSUCH  = 3'd2,
    STAT_NOREADY = 3'd3,
    STAT_ALLDONE = 3'd4
  } status_e;

  // Scan match masks, one bit per state code
  localparam logic [7:0] MASK_READY = 8'b0000_0010;
  localparam logic [7:0] MASK_CLEAN = 8'b0001_0000;
  localparam logic [7:0] MASK_ALIVE = 8'b0000_0111;  // running, ready, blocked

  typedef struct packed {
    logic       start;
    logic [7:0] mask;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

>>> hw/rtl/rrts_table.sv
module rrts_table #(
  parameter int unsigned SLOTS      = 128,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IDW        = 7
) (
  input  logic                     clk_i,
  input  logic [IDW-1:0]           rd_addr_i,
  input  logic [IDW-1:0]           wr_addr_i,
  input  logic                     state_we_i,
  input  rrts_pkg::slot_state_e    state_wd_i,
  input  logic                     waiter_we_i,
  input  logic [IDW-1:0]           waiter_wd_i,
  input  logic                     value_we_i,
  input  logic [VALUE_BITS-1:0]    value_wd_i,
  output rrts_pkg::slot_state_e    state_rd_o,
  output logic [IDW-1:0]           waiter_rd_o,
  output logic [VALUE_BITS-1:0]    value_rd_o
);
  import rrts_pkg::*;

  slot_state_e           state_mem  [SLOTS];
  logic [IDW-1:0]        waiter_mem [SLOTS];
  logic [VALUE_BITS-1:0] value_mem  [SLOTS];

  slot_state_e           state_rd_q;
  logic [IDW-1:0]        waiter_rd_q;
  logic [VALUE_BITS-1:0] value_rd_q;

  // One write address shared by the three arrays, separate enables
  always_ff @(posedge clk_i) begin
    if (state_we_i) begin
      state_mem[wr_addr_i] <= state_wd_i;
    end
    if (waiter_we_i) begin
      waiter_mem[wr_addr_i] <= waiter_wd_i;
    end
    if (value_we_i) begin
      value_mem[wr_addr_i] <= value_wd_i;
    end
  end

  // Registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    state_rd_q  <= state_mem[rd_addr_i];
    waiter_rd_q <= waiter_mem[rd_addr_i];
    value_rd_q  <= value_mem[rd_addr_i];
  end

  assign state_rd_o  = state_rd_q;
  assign waiter_rd_o = waiter_rd_q;
  assign value_rd_o  = value_rd_q;

endmodule

>>> hw/rtl/rrts_scan.sv
module rrts_scan #(
  parameter int unsigned SLOTS = 128,
  parameter int unsigned IDW   = 7,
  parameter int unsigned CNTW  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrts_pkg::scan_req_t   req_i,
  input  logic [IDW-1:0]        start_idx_i,
  input  logic [CNTW-1:0]       count_i,
  output logic [IDW-1:0]        rd_addr_o,
  input  rrts_pkg::slot_state_e rd_state_i,
  output rrts_pkg::scan_rsp_t   rsp_o,
  output logic [IDW-1:0]        hit_idx_o
);
  import rrts_pkg::*;

  logic            busy_q, busy_d;
  logic            pend_q, pend_d;
  logic [IDW-1:0]  ptr_q, ptr_d;
  logic [IDW-1:0]  pend_addr_q, pend_addr_d;
  logic [CNTW-1:0] left_q, left_d;
  logic [7:0]      mask_q, mask_d;
  logic            hit_now, miss_now, issue;

  // Compare the returned state of the previous probe, issue the next one
  always_comb begin
    hit_now  = pend_q && mask_q[rd_state_i];
    miss_now = busy_q && (left_q == '0) && !hit_now;
    issue    = busy_q && (left_q != '0) && !hit_now;

    busy_d      = busy_q && !(hit_now || miss_now);
    pend_d      = issue;
    ptr_d       = ptr_q;
    left_d      = left_q;
    mask_d      = mask_q;
    pend_addr_d = pend_addr_q;

    if (issue) begin
      pend_addr_d = ptr_q;
      left_d      = left_q - 1'b1;
      ptr_d       = (ptr_q == IDW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
    end

    if (req_i.start) begin
      busy_d = 1'b1;
      pend_d = 1'b0;
      ptr_d  = start_idx_i;
      left_d = count_i;
      mask_d = req_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    left_q      <= left_d;
    mask_q      <= mask_d;
    pend_addr_q <= pend_addr_d;
  end

  assign rd_addr_o  = ptr_q;
  assign hit_idx_o  = pend_addr_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = hit_now || miss_now;
  assign rsp_o.hit  = hit_now;

endmodule

>>> hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler: a table of THREAD_SLOTS thread slots (state, waiter, exit value)
// plus the running slot, driven one request beat at a time (tick, create, exit, join), each
// giving one result beat. Every search goes through a single scan unit that probes one slot per
// cycle over the table's one read port, so timing is set by that linear scan. A tick or a blocking
// join scans once for a ready slot; create scans for a clean slot and then for a ready one (only
// the first when the table is full); exit scans for a live slot and then, if one is found, for a
// ready one; a join that reaps or fails does no scan. A scan that hits early ends sooner. The
// block takes one request at a time; a new request is accepted while the previous result still
// waits on the output. After reset a clearing pass over every slot initializes the table, and no
// request is accepted until it ends. Slot numbers on the outputs are the low 7 bits of the slot.
module round_robin_thread_scheduler #(
  parameter int unsigned THREAD_SLOTS = 128,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [rrts_pkg::ID_W-1:0]  target_id_i,
  input  logic [rrts_pkg::VAL_W-1:0] exit_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [rrts_pkg::ID_W-1:0]  running_id_o,
  output logic [rrts_pkg::ID_W-1:0]  new_thread_id_o,
  output logic [rrts_pkg::VAL_W-1:0] join_value_o,
  output logic                       woken_valid_o,
  output logic [rrts_pkg::ID_W-1:0]  woken_id_o
);
  import rrts_pkg::*;

  localparam int unsigned IDW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned VB   = VALUE_BITS;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_RD_CUR  = 12'b0000_0000_0100,
    S_EV_CUR  = 12'b0000_0000_1000,
    S_WAKE    = 12'b0000_0001_0000,
    S_ALIVE   = 12'b0000_0010_0000,
    S_PICK    = 12'b0000_0100_0000,
    S_NEWSCAN = 12'b0000_1000_0000,
    S_RD_TGT  = 12'b0001_0000_0000,
    S_EV_TGT  = 12'b0010_0000_0000,
    S_JOINW   = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } seq_state_e;

  seq_state_e     state_q, state_d;
  logic [IDW-1:0] clr_q, clr_d;
  logic [IDW-1:0] cur_q, cur_d;

  // Request beat as taken
  op_e            op_q, op_d;
  logic [ID_W-1:0] tgt_q, tgt_d;
  logic [VAL_W-1:0] val_q, val_d;

  // Result being built
  status_e        res_status_q, res_status_d;
  logic [IDW-1:0] res_new_q, res_new_d;
  logic [VB-1:0]  res_join_q, res_join_d;
  logic           res_wv_q, res_wv_d;
  logic [IDW-1:0] res_wid_q, res_wid_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [ID_W-1:0]  out_run_q, out_run_d;
  logic [ID_W-1:0]  out_new_q, out_new_d;
  logic [VAL_W-1:0] out_join_q, out_join_d;
  logic             out_wv_q, out_wv_d;
  logic [ID_W-1:0]  out_wid_q, out_wid_d;

  // Table ports
  logic [IDW-1:0] seq_rd_addr, tbl_rd_addr, wr_addr;
  logic           state_we, waiter_we, value_we;
  slot_state_e    state_wd, state_rd;
  logic [IDW-1:0] waiter_wd, waiter_rd;
  logic [VB-1:0]  value_wd, value_rd;

  // Scan unit ports
  scan_req_t      scan_req;
  scan_rsp_t      scan_rsp;
  logic [IDW-1:0] scan_start, scan_addr, scan_idx;
  logic [CNTW-1:0] scan_count;

  // Width adaptation between slot indices, 7-bit ids and values
  logic [IDW+ID_W-1:0]  tgt_ext, cur_ext, new_ext, wid_ext;
  logic [VB+VAL_W-1:0]  val_ext;
  logic [VAL_W+VB-1:0]  join_ext;
  logic [IDW-1:0]       tgt_idx, cur_next;
  logic [VB-1:0]        val_masked;

  assign tgt_ext    = {{IDW{1'b0}}, tgt_q};
  assign tgt_idx    = tgt_ext[IDW-1:0];
  assign cur_ext    = {{ID_W{1'b0}}, cur_q};
  assign new_ext    = {{ID_W{1'b0}}, res_new_q};
  assign wid_ext    = {{ID_W{1'b0}}, res_wid_q};
  assign val_ext    = {{VB{1'b0}}, val_q};
  assign val_masked = val_ext[VB-1:0];
  assign join_ext   = {{VAL_W{1'b0}}, res_join_q};
  assign cur_next   = (cur_q == IDW'(THREAD_SLOTS - 1)) ? '0 : cur_q + 1'b1;

  assign tbl_rd_addr = scan_rsp.busy ? scan_addr : seq_rd_addr;

  rrts_table #(
    .SLOTS      (THREAD_SLOTS),
    .VALUE_BITS (VB),
    .IDW        (IDW)
  ) u_table (
    .clk_i       (clk_i),
    .rd_addr_i   (tbl_rd_addr),
    .wr_addr_i   (wr_addr),
    .state_we_i  (state_we),
    .state_wd_i  (state_wd),
    .waiter_we_i (waiter_we),
    .waiter_wd_i (waiter_wd),
    .value_we_i  (value_we),
    .value_wd_i  (value_wd),
    .state_rd_o  (state_rd),
    .waiter_rd_o (waiter_rd),
    .value_rd_o  (value_rd)
  );

  rrts_scan #(
    .SLOTS (THREAD_SLOTS),
    .IDW   (IDW),
    .CNTW  (CNTW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (scan_req),
    .start_idx_i (scan_start),
    .count_i     (scan_count),
    .rd_addr_o   (scan_addr),
    .rd_state_i  (state_rd),
    .rsp_o       (scan_rsp),
    .hit_idx_o   (scan_idx)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    op_d         = op_q;
    tgt_d        = tgt_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_new_d    = res_new_q;
    res_join_d   = res_join_q;
    res_wv_d     = res_wv_q;
    res_wid_d    = res_wid_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_run_d    = out_run_q;
    out_new_d    = out_new_q;
    out_join_d   = out_join_q;
    out_wv_d     = out_wv_q;
    out_wid_d    = out_wid_q;

    seq_rd_addr = cur_q;
    wr_addr     = cur_q;
    state_we    = 1'b0;
    state_wd    = ST_CLEAN;
    waiter_we   = 1'b0;
    waiter_wd   = cur_q;
    value_we    = 1'b0;
    value_wd    = val_masked;

    scan_req.start = 1'b0;
    scan_req.mask  = MASK_READY;
    scan_start     = cur_next;
    scan_count     = CNTW'(THREAD_SLOTS);

    case (state_q)
      // Reset sweep: slot 0 running, the rest clean, each waiting on itself
      S_CLEAR: begin
        wr_addr   = clr_q;
        state_we  = 1'b1;
        state_wd  = (clr_q == '0) ? ST_RUNNING : ST_CLEAN;
        waiter_we = 1'b1;
        waiter_wd = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDW'(THREAD_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(op_i);
          tgt_d        = target_id_i;
          val_d        = exit_value_i;
          res_status_d = STAT_OK;
          res_new_d    = '0;
          res_join_d   = '0;
          res_wv_d     = 1'b0;
          res_wid_d    = '0;
          case (op_e'(op_i))
            OP_TICK, OP_EXIT: begin
              state_d = S_RD_CUR;
            end
            OP_CREATE: begin
              scan_req.start = 1'b1;
              scan_req.mask  = MASK_CLEAN;
              scan_start     = IDW'(1);
              scan_count     = CNTW'(THREAD_SLOTS - 1);
              state_d        = S_NEWSCAN;
            end
            OP_JOIN: begin
              if (int'(target_id_i) >= int'(THREAD_SLOTS)) begin
                res_status_d = STAT_NOSUCH;
                state_d      = S_DONE;
              end else begin
                state_d = S_RD_TGT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_RD_CUR: begin
        seq_rd_addr = cur_q;
        state_d     = S_EV_CUR;
      end

      S_EV_CUR: begin
        if (op_q == OP_EXIT) begin
          // Runner finishes; a distinct waiter is woken and the runner reaped
          value_we = 1'b1;
          if (waiter_rd != cur_q) begin
            state_we   = 1'b1;
            state_wd   = ST_CLEAN;
            waiter_we  = 1'b1;
            waiter_wd  = cur_q;
            res_wv_d   = 1'b1;
            res_wid_d  = waiter_rd;
            res_join_d = val_masked;
            state_d    = S_WAKE;
          end else begin
            state_we       = 1'b1;
            state_wd       = ST_ZOMBIE;
            scan_req.start = 1'b1;
            scan_req.mask  = MASK_ALIVE;
            scan_start     = '0;
            state_d        = S_ALIVE;
          end
        end else begin
          // Preempt the runner, then pick the next ready slot
          if (state_rd == ST_RUNNING) begin
            state_we = 1'b1;
            state_wd = ST_READY;
          end
          scan_req.start = 1'b1;
          state_d        = S_PICK;
        end
      end

      S_WAKE: begin
        wr_addr        = res_wid_q;
        state_we       = 1'b1;
        state_wd       = ST_READY;
        scan_req.start = 1'b1;
        scan_req.mask  = MASK_ALIVE;
        scan_start     = '0;
        state_d        = S_ALIVE;
      end

      S_ALIVE: begin
        if (scan_rsp.done) begin
          if (scan_rsp.hit) begin
            scan_req.start = 1'b1;
            state_d        = S_PICK;
          end else begin
            res_status_d = STAT_ALLDONE;
            state_d      = S_DONE;
          end
        end
      end

      S_PICK: begin
        if (scan_rsp.done) begin
          if (scan_rsp.hit) begin
            wr_addr      = scan_idx;
            state_we     = 1'b1;
            state_wd     = ST_RUNNING;
            cur_d        = scan_idx;
            res_status_d = STAT_OK;
          end else begin
            res_status_d = STAT_NOREADY;
          end
          state_d = S_DONE;
        end
      end

      S_NEWSCAN: begin
        if (scan_rsp.done) begin
          if (scan_rsp.hit) begin
            wr_addr   = scan_idx;
            state_we  = 1'b1;
            state_wd  = ST_READY;
            waiter_we = 1'b1;
            waiter_wd = scan_idx;
            res_new_d = scan_idx;
            state_d   = S_RD_CUR;
          end else begin
            res_status_d = STAT_FULL;
            state_d      = S_DONE;
          end
        end
      end

      S_RD_TGT: begin
        seq_rd_addr = tgt_idx;
        state_d     = S_EV_TGT;
      end

      S_EV_TGT: begin
        case (state_rd)
          ST_RUNNING, ST_READY, ST_BLOCKED: begin
            state_we = 1'b1;
            state_wd = ST_BLOCKED;
            state_d  = S_JOINW;
          end
          ST_ZOMBIE: begin
            // Reap the finished target and hand back its value
            res_join_d = value_rd;
            wr_addr    = tgt_idx;
            state_we   = 1'b1;
            state_wd   = ST_CLEAN;
            waiter_we  = 1'b1;
            waiter_wd  = tgt_idx;
            state_d    = S_DONE;
          end
          default: begin
            res_status_d = STAT_NOSUCH;
            state_d      = S_DONE;
          end
        endcase
      end

      S_JOINW: begin
        wr_addr        = tgt_idx;
        waiter_we      = 1'b1;
        waiter_wd      = cur_q;
        scan_req.start = 1'b1;
        state_d        = S_PICK;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_run_d    = cur_ext[ID_W-1:0];
          out_new_d    = new_ext[ID_W-1:0];
          out_join_d   = join_ext[VAL_W-1:0];
          out_wv_d     = res_wv_q;
          out_wid_d    = wid_ext[ID_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tgt_q        <= tgt_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_new_q    <= res_new_d;
    res_join_q   <= res_join_d;
    res_wv_q     <= res_wv_d;
    res_wid_q    <= res_wid_d;
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_new_q    <= out_new_d;
    out_join_q   <= out_join_d;
    out_wv_q     <= out_wv_d;
    out_wid_q    <= out_wid_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign running_id_o    = out_run_q;
  assign new_thread_id_o = out_new_q;
  assign join_value_o    = out_join_q;
  assign woken_valid_o   = out_wv_q;
  assign woken_id_o      = out_wid_q;

endmodule

>>> hw/rtl/rrts_chk.sv
module rrts_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [2:0]                 status_o,
  input logic [rrts_pkg::ID_W-1:0]  running_id_o,
  input logic [rrts_pkg::ID_W-1:0]  new_thread_id_o,
  input logic [rrts_pkg::VAL_W-1:0] join_value_o,
  input logic                       woken_valid_o,
  input logic [rrts_pkg::ID_W-1:0]  woken_id_o
);
  import rrts_pkg::*;

  // A stalled result beat holds its status, running id and join value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(running_id_o) && $stable(join_value_o))
    else $error("result beat changed while stalled");

  // One request in flight: ready drops after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // Waking a joiner always leaves a ready thread to run
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_valid_o |-> status_o == STAT_OK)
    else $error("wake without a successful pick");

  // A created thread is always runnable
  a_create_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (new_thread_id_o != '0) |-> status_o == STAT_OK)
    else $error("create gave a slot but the pick failed");

  // No woken id without a wake
  a_wid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !woken_valid_o |-> woken_id_o == '0)
    else $error("woken id set without a wake");

endmodule

bind round_robin_thread_scheduler rrts_chk u_rrts_chk (.*);
